### sv/wpool_pkg.sv
// Shared constants, register indexes and the reciprocal helper function for window pooling.
`default_nettype none
package wpool_pkg;

  localparam int MAX_SCALE    = 8;
  localparam int MAX_OUT_COLS = 256;
  localparam int SAMPLE_BITS  = 16;
  localparam int ACC_W        = 40;
  localparam int COL_AW       = $clog2(MAX_OUT_COLS);
  localparam int RECIP_SHIFT  = 15;
  localparam int RECIP_W      = 16;
  localparam int MAX_IN_COLS  = 4096;
  localparam int MAX_OUT_ROWS = 4096;

  localparam logic [1:0] MODE_MEAN = 2'd0;
  localparam logic [1:0] MODE_MAX  = 2'd1;
  localparam logic [1:0] MODE_L2   = 2'd2;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_SCALE    = 3'd1;
  localparam logic [2:0] REG_OUT_ROWS = 3'd2;
  localparam logic [2:0] REG_OUT_COLS = 3'd3;
  localparam logic [2:0] REG_IN_COLS  = 3'd4;

  // ceil(2^15 / d): exact quotient for dividends up to 2^12 and d up to 8
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] d);
    logic [RECIP_W-1:0] r;
    begin
      unique case (d)
        4'd1:    r = 16'd32768;
        4'd2:    r = 16'd16384;
        4'd3:    r = 16'd10923;
        4'd4:    r = 16'd8192;
        4'd5:    r = 16'd6554;
        4'd6:    r = 16'd5462;
        4'd7:    r = 16'd4682;
        default: r = 16'd4096;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

### sv/window_pooling_top.sv
// Window pooling engine: streams a raster and pools scale x scale windows.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one raster sample per transaction
//   in row-major order; in_frame_start marks the first sample of a frame and
//   rewinds the position counters. Output channel (out_valid/out_ready) carries
//   one pooled value per completed window, with out_frame_last on the final
//   window of the frame. Configuration writes go through cfg_we/cfg_index/
//   cfg_wdata and take effect at once; write them only while the block is idle.
// Sequence:
//   Each sample passes through accept, reciprocal multiply and accumulator read,
//   plus a write-back when it lands in the pooled region. A window's
//   bottom-right sample then goes straight to the emit state in max mode, and
//   first through the divider (one quotient bit a cycle) in mean mode or the
//   root unit in L2 mode. A new sample is taken only after the previous one is
//   done. The accumulator memory read/modify/write paces the samples; the
//   divider and the root unit pace the windows.
// Reset:
//   Position counters clear, registers return to mode max, scale 2, one output
//   row and column, two input columns. Accumulators are not cleared; each
//   window's first sample seeds its own entry.
// Stall:
//   A finished result waits in the output register; the next sample is taken
//   while it waits, and only a second result stalls until out_ready.
`default_nettype none
module window_pooling_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [wpool_pkg::SAMPLE_BITS-1:0] in_sample,
  input  wire logic                                 in_frame_start,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [wpool_pkg::SAMPLE_BITS-1:0]  out_pooled,
  output logic                                      out_frame_last,
  input  wire logic                                 cfg_we,
  input  wire logic [2:0]                           cfg_index,
  input  wire logic [12:0]                          cfg_wdata
);

  localparam int SB = wpool_pkg::SAMPLE_BITS;
  localparam int AW = wpool_pkg::ACC_W;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_RD   = 7'b0000100,
    ST_UPD  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_SQRT = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  state_t state_r;

  // configuration registers
  logic [1:0]  mode_r;
  logic [3:0]  scale_r;
  logic [12:0] out_rows_r;
  logic [8:0]  out_cols_r;
  logic [12:0] in_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= wpool_pkg::MODE_MAX;
      scale_r    <= 4'd2;
      out_rows_r <= 13'd1;
      out_cols_r <= 9'd1;
      in_cols_r  <= 13'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wpool_pkg::REG_MODE:     mode_r     <= cfg_wdata[1:0];
        wpool_pkg::REG_SCALE:    scale_r    <= cfg_wdata[3:0];
        wpool_pkg::REG_OUT_ROWS: out_rows_r <= cfg_wdata;
        wpool_pkg::REG_OUT_COLS: out_cols_r <= cfg_wdata[8:0];
        wpool_pkg::REG_IN_COLS:  in_cols_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective limits
  logic [3:0]  sc_c;
  logic [12:0] ic_c;
  logic [12:0] orow_c;
  logic [8:0]  ocl_c;
  logic [6:0]  sc_sq_c;

  always_comb begin
    if (scale_r == 4'd0) sc_c = 4'd1;
    else if (scale_r > 4'(wpool_pkg::MAX_SCALE)) sc_c = 4'(wpool_pkg::MAX_SCALE);
    else sc_c = scale_r;
    if (in_cols_r == 13'd0) ic_c = 13'd1;
    else if (in_cols_r > 13'(wpool_pkg::MAX_IN_COLS)) ic_c = 13'(wpool_pkg::MAX_IN_COLS);
    else ic_c = in_cols_r;
    orow_c = (out_rows_r > 13'(wpool_pkg::MAX_OUT_ROWS)) ?
             13'(wpool_pkg::MAX_OUT_ROWS) : out_rows_r;
    ocl_c  = (out_cols_r > 9'(wpool_pkg::MAX_OUT_COLS)) ?
             9'(wpool_pkg::MAX_OUT_COLS) : out_cols_r;
    sc_sq_c = 7'({3'd0, sc_c} * {3'd0, sc_c});
  end

  // windows that fit the raster: ic / sc by reciprocal, two register stages
  logic [28:0] icq_prod_r;
  logic [8:0]  oc_r;
  logic [12:0] icq_c;

  assign icq_c = icq_prod_r[wpool_pkg::RECIP_SHIFT +: 13];

  always_ff @(posedge clk) begin
    icq_prod_r <= 29'(ic_c) * 29'(wpool_pkg::recip(sc_c));
    oc_r       <= ({4'd0, ocl_c} < icq_c) ? ocl_c : icq_c[8:0];
  end

  // position counters
  logic [11:0] col_r;
  logic [3:0]  riw_r;
  logic [12:0] wrow_r;

  // item registers
  logic signed [SB-1:0] samp_r;
  logic [27:0]          prod_r;
  logic [wpool_pkg::COL_AW-1:0] k_r;
  logic                 seed_r;
  logic                 last_r;
  logic                 flast_r;
  logic [AW-1:0]        contrib_r;
  logic [AW-1:0]        rd_data_r;

  // iterative units
  logic [AW-1:0] dvd_r;
  logic [6:0]    rem_r;
  logic [5:0]    cnt_r;
  logic          neg_r;
  logic [AW-1:0] x_r;
  logic [AW-1:0] root_r;
  logic [AW-1:0] bit_r;
  logic [SB-1:0] res_r;
  logic          res_last_r;

  logic out_valid_r;
  logic [SB-1:0] out_pooled_r;
  logic out_frame_last_r;

  logic [wpool_pkg::COL_AW-1:0] mem_waddr;
  logic [AW-1:0]                mem_wdata;
  logic                         mem_we;
  logic [AW-1:0]                mem [wpool_pkg::MAX_OUT_COLS];

  // read stage decode
  logic [11:0] k_c;
  logic [11:0] n_c;
  logic        active_c;
  logic [16:0] mag_c;
  logic [AW-1:0] sext_c;
  logic [12:0] col_inc_c;
  logic [3:0]  riw_inc_c;

  always_comb begin
    k_c       = prod_r[wpool_pkg::RECIP_SHIFT +: 12];
    n_c       = col_r - 12'(k_c * {8'd0, sc_c});
    active_c  = (wrow_r < orow_c) && (oc_r != 9'd0) && ({1'b0, k_c} < {4'd0, oc_r});
    sext_c    = {{(AW-SB){samp_r[SB-1]}}, samp_r};
    mag_c     = samp_r[SB-1] ? (17'd0 - {samp_r[SB-1], samp_r}) : {1'b0, samp_r};
    col_inc_c = {1'b0, col_r} + 13'd1;
    riw_inc_c = riw_r + 4'd1;
  end

  // update stage
  logic [AW-1:0] acc_new_c;

  always_comb begin
    if (seed_r) begin
      acc_new_c = contrib_r;
    end else if (mode_r == wpool_pkg::MODE_MEAN || mode_r == wpool_pkg::MODE_L2) begin
      acc_new_c = rd_data_r + contrib_r;
    end else if ($signed(contrib_r) > $signed(rd_data_r)) begin
      acc_new_c = contrib_r;
    end else begin
      acc_new_c = rd_data_r;
    end
    mem_we    = state_r == ST_UPD;
    mem_waddr = k_r;
    mem_wdata = acc_new_c;
  end

  // divider and root steps
  logic [7:0]    rem_sh_c;
  logic          qbit_c;
  logic [AW-1:0] quo_c;
  logic [AW-1:0] root_try_c;
  logic          root_ge_c;
  logic [AW-1:0] root_next_c;

  always_comb begin
    rem_sh_c    = {rem_r, dvd_r[AW-1]};
    qbit_c      = rem_sh_c >= {1'b0, sc_sq_c};
    quo_c       = {dvd_r[AW-2:0], qbit_c};
    root_try_c  = root_r + bit_r;
    root_ge_c   = x_r >= root_try_c;
    root_next_c = root_ge_c ? ((root_r >> 1) + bit_r) : (root_r >> 1);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == ST_RD) begin
      rd_data_r <= mem[k_c[wpool_pkg::COL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= 12'd0;
      riw_r   <= 4'd0;
      wrow_r  <= 13'd0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            samp_r <= in_sample;
            if (in_frame_start) begin
              col_r  <= 12'd0;
              riw_r  <= 4'd0;
              wrow_r <= 13'd0;
            end
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= 28'(col_r) * 28'(wpool_pkg::recip(sc_c));
          state_r <= ST_RD;
        end
        ST_RD: begin
          k_r       <= k_c[wpool_pkg::COL_AW-1:0];
          seed_r    <= (riw_r == 4'd0) && (n_c == 12'd0);
          last_r    <= (riw_r == sc_c - 4'd1) && (n_c == {8'd0, sc_c - 4'd1});
          flast_r   <= (wrow_r == orow_c - 13'd1) && ({1'b0, k_c} == {4'd0, oc_r} - 13'd1);
          contrib_r <= (mode_r == wpool_pkg::MODE_L2) ? AW'({17'd0, mag_c} * {17'd0, mag_c})
                                                      : sext_c;
          // advance position
          if (col_inc_c >= ic_c) begin
            col_r <= 12'd0;
            if (riw_inc_c >= sc_c) begin
              riw_r <= 4'd0;
              if (wrow_r < 13'(wpool_pkg::MAX_OUT_ROWS)) wrow_r <= wrow_r + 13'd1;
            end else begin
              riw_r <= riw_inc_c;
            end
          end else begin
            col_r <= col_inc_c[11:0];
          end
          state_r <= active_c ? ST_UPD : ST_IDLE;
        end
        ST_UPD: begin
          res_last_r <= flast_r;
          if (!last_r) begin
            state_r <= ST_IDLE;
          end else if (mode_r == wpool_pkg::MODE_MEAN) begin
            neg_r   <= acc_new_c[AW-1];
            dvd_r   <= acc_new_c[AW-1] ? (AW'(0) - acc_new_c) : acc_new_c;
            rem_r   <= 7'd0;
            cnt_r   <= 6'(AW);
            state_r <= ST_DIV;
          end else if (mode_r == wpool_pkg::MODE_L2) begin
            x_r     <= acc_new_c;
            root_r  <= '0;
            bit_r   <= AW'(1) << (AW - 2);
            state_r <= ST_SQRT;
          end else begin
            res_r   <= acc_new_c[SB-1:0];
            state_r <= ST_EMIT;
          end
        end
        ST_DIV: begin
          rem_r <= qbit_c ? 7'(rem_sh_c - {1'b0, sc_sq_c}) : rem_sh_c[6:0];
          dvd_r <= quo_c;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            res_r   <= neg_r ? SB'(AW'(0) - quo_c) : quo_c[SB-1:0];
            state_r <= ST_EMIT;
          end
        end
        ST_SQRT: begin
          if (root_ge_c) x_r <= x_r - root_try_c;
          root_r <= root_next_c;
          bit_r  <= bit_r >> 2;
          if (bit_r[0]) begin
            res_r   <= (root_next_c > AW'((1 << (SB - 1)) - 1)) ?
                       SB'((1 << (SB - 1)) - 1) : root_next_c[SB-1:0];
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && (!out_valid_r || out_ready)) begin
      out_pooled_r     <= res_r;
      out_frame_last_r <= res_last_r;
    end
  end

  assign in_ready       = state_r == ST_IDLE;
  assign out_valid      = out_valid_r;
  assign out_pooled     = out_pooled_r;
  assign out_frame_last = out_frame_last_r;

endmodule
`default_nettype wire

### sv/wpool_checker.sv
// Port-level checker for the window pooling engine, bound to the top level.
`default_nettype none
module wpool_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [wpool_pkg::SAMPLE_BITS-1:0]  out_pooled,
  input wire logic                               out_frame_last
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pooled) && $stable(out_frame_last))
    else $error("stalled result changed");

  // one sample in flight: ready drops after each transaction
  a_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while another is in flight");

  // no result shows right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a result does not rise too early after a sample
  a_min_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind window_pooling_top wpool_checker u_wpool_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_pooled     (out_pooled),
  .out_frame_last (out_frame_last)
);
`default_nettype wire

### tb/window_pooling_top_tb.sv
// Self-checking testbench for the window pooling engine.
`timescale 1ns / 1ps
`default_nettype none
module window_pooling_top_tb;

  // Cycles that the slowest window (mean, bit-serial divide) may still take
  // after its last sample; also the quiet time before a register write.
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 5000;
  localparam int ITEM_TARGET   = 1050;

  typedef struct packed {
    logic [15:0] pooled;
    logic        last;
  } pooled_t;

  // One row of the directed table: a register write or one sample.
  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [12:0] val;
    logic [15:0] sample;
    bit          fs;
    bit          typed;
    logic [15:0] want_pooled;
    bit          want_last;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [wpool_pkg::SAMPLE_BITS-1:0] in_sample = '0;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [wpool_pkg::SAMPLE_BITS-1:0] out_pooled;
  logic out_frame_last;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [12:0] cfg_wdata = '0;

  window_pooling_top dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_sample, .in_frame_start,
    .out_valid, .out_ready, .out_pooled, .out_frame_last,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always #6 clk = ~clk;

  // Predictor state: accumulators, position counters and register copies.
  logic [63:0] col_acc [wpool_pkg::MAX_OUT_COLS];
  int unsigned pos_col, pos_row, win_line, win_row_idx;
  int unsigned r_mode, r_scale, r_out_rows, r_out_cols, r_in_cols;

  pooled_t pending_pooled[$];
  int unsigned fail_count = 0;
  int unsigned used_samples = 0;
  int unsigned sent_samples = 0;
  int unsigned pooled_seen = 0;
  int unsigned cfg_sets = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  bit need_frame_start = 1'b1;

  function automatic logic [63:0] floor_root(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Advance the pooling state by one sample; return 1 if a window completes.
  function automatic bit pool_sample(input logic [15:0] s, input bit fs,
                                     output pooled_t res);
    logic signed [63:0] v, q;
    logic [63:0] mag, contrib, acc, val;
    int unsigned sc, ic, orow, oc, k, n;
    bit hit;
    hit = 0;
    res = '0;
    v = {{48{s[15]}}, s};
    if (fs) begin
      pos_col = 0; pos_row = 0; win_line = 0; win_row_idx = 0;
    end
    sc = (r_scale == 0) ? 1 : r_scale;
    if (sc > wpool_pkg::MAX_SCALE) sc = wpool_pkg::MAX_SCALE;
    ic = (r_in_cols == 0) ? 1 : r_in_cols;
    if (ic > wpool_pkg::MAX_IN_COLS) ic = wpool_pkg::MAX_IN_COLS;
    orow = (r_out_rows > wpool_pkg::MAX_OUT_ROWS) ? wpool_pkg::MAX_OUT_ROWS : r_out_rows;
    oc = (r_out_cols > wpool_pkg::MAX_OUT_COLS) ? wpool_pkg::MAX_OUT_COLS : r_out_cols;
    if (oc > ic / sc) oc = ic / sc;
    if (win_row_idx < orow && oc > 0) begin
      k = pos_col / sc;
      n = pos_col % sc;
      if (k < oc) begin
        used_samples++;
        mag = (v < 0) ? -v : v;
        contrib = (r_mode == wpool_pkg::MODE_L2) ? mag * mag : v;
        acc = col_acc[k];
        if (win_line == 0 && n == 0) acc = contrib;
        else if (r_mode == wpool_pkg::MODE_MEAN || r_mode == wpool_pkg::MODE_L2)
          acc += contrib;
        else if (v > $signed(acc)) acc = v;
        col_acc[k] = acc;
        if (win_line == sc - 1 && n == sc - 1) begin
          if (r_mode == wpool_pkg::MODE_MEAN) begin
            q = $signed(acc);
            val = ((q < 0) ? -q : q) / (sc * sc);
            val = (q < 0) ? -val : val;
          end else if (r_mode == wpool_pkg::MODE_L2) begin
            val = floor_root(acc);
            if (val > 32767) val = 32767;
          end else begin
            val = acc;
          end
          res.pooled = val[15:0];
          res.last = (win_row_idx == orow - 1 && k == oc - 1);
          hit = 1;
        end
      end
    end
    if (pos_col + 1 >= ic) begin
      pos_col = 0;
      pos_row = (pos_row + 1) & 12'hFFF;
      win_line++;
      if (win_line >= sc) begin
        win_line = 0;
        if (win_row_idx < wpool_pkg::MAX_OUT_ROWS) win_row_idx++;
      end
    end else begin
      pos_col++;
    end
    return hit;
  endfunction

  // Send one sample; hold valid until the transaction completes, then predict.
  task automatic send_sample(input logic [15:0] s, input bit fs, input bit typed,
                             input pooled_t want);
    pooled_t res;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 30);
    end
    fs = fs | need_frame_start;
    need_frame_start = 1'b0;
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample <= s;
    in_frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    sent_samples++;
    if (pool_sample(s, fs, res)) pending_pooled.push_back(typed ? want : res);
  endtask

  // Drop valid, wait out every expected result plus in-flight work.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pooled.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      wpool_pkg::REG_MODE:     r_mode = val[1:0];
      wpool_pkg::REG_SCALE:    r_scale = val[3:0];
      wpool_pkg::REG_OUT_ROWS: r_out_rows = val;
      wpool_pkg::REG_OUT_COLS: r_out_cols = val[8:0];
      wpool_pkg::REG_IN_COLS:  r_in_cols = val;
      default: ;
    endcase
    need_frame_start = 1'b1;
  endtask

  task automatic write_all(input int unsigned m, sc, orows, ocols, icols);
    drain();
    write_reg(wpool_pkg::REG_MODE, m[12:0]);
    write_reg(wpool_pkg::REG_SCALE, sc[12:0]);
    write_reg(wpool_pkg::REG_OUT_ROWS, orows[12:0]);
    write_reg(wpool_pkg::REG_OUT_COLS, ocols[12:0]);
    write_reg(wpool_pkg::REG_IN_COLS, icols[12:0]);
    cfg_sets++;
  endtask

  function automatic logic [15:0] pick_sample;
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return ($urandom_range(0, 1)) ? 16'h0000 : 16'hFFFF;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Receiver: alternate stretches of always-ready, coin-flip and long stalls.
  int unsigned rdy_left = 0;
  int unsigned rdy_kind = 0;
  always @(negedge clk) begin
    if (rdy_left == 0) begin
      rdy_left = $urandom_range(1, 40);
      rdy_kind = $urandom_range(0, 2);
    end
    rdy_left--;
    case (rdy_kind)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ((rdy_left % 10) < 2);
    endcase
  end

  // Compare each pooled transaction with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      pooled_seen++;
      if (pending_pooled.size() == 0) begin
        $display("%0t: unexpected result pooled=%h last=%b", $time,
                 out_pooled, out_frame_last);
        fail_count++;
      end else begin
        if (out_pooled !== pending_pooled[0].pooled) begin
          $display("%0t: pooled mismatch expected %h actual %h", $time,
                   pending_pooled[0].pooled, out_pooled);
          fail_count++;
        end
        if (out_frame_last !== pending_pooled[0].last) begin
          $display("%0t: frame_last mismatch expected %b actual %b", $time,
                   pending_pooled[0].last, out_frame_last);
          fail_count++;
        end
        void'(pending_pooled.pop_front());
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               pending_pooled.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Directed table. Reset leaves max mode, 2x2 windows, one output.
  step_row_t dir_rows[] = '{
    '{0, wpool_pkg::REG_MODE, 0, 16'h7FFF, 1, 0, 0, 0},
    '{0, wpool_pkg::REG_MODE, 0, 16'h8000, 0, 0, 0, 0},
    '{0, wpool_pkg::REG_MODE, 0, 16'h0000, 0, 0, 0, 0},
    '{0, wpool_pkg::REG_MODE, 0, 16'h0001, 0, 1, 16'h7FFF, 1},
    '{0, wpool_pkg::REG_MODE, 0, 16'h8000, 1, 0, 0, 0},
    '{0, wpool_pkg::REG_MODE, 0, 16'h8000, 0, 0, 0, 0},
    '{0, wpool_pkg::REG_MODE, 0, 16'h8000, 0, 0, 0, 0},
    '{0, wpool_pkg::REG_MODE, 0, 16'h8000, 0, 1, 16'h8000, 1},
    // frame complete: these are dropped
    '{0, wpool_pkg::REG_MODE, 0, 16'h1234, 0, 0, 0, 0},
    '{0, wpool_pkg::REG_MODE, 0, 16'h4321, 0, 0, 0, 0},
    // 1x1 windows, L2 of the most negative sample saturates
    '{1, wpool_pkg::REG_SCALE, 1, 0, 0, 0, 0, 0},
    '{1, wpool_pkg::REG_IN_COLS, 1, 0, 0, 0, 0, 0},
    '{1, wpool_pkg::REG_MODE, wpool_pkg::MODE_L2, 0, 0, 0, 0, 0},
    '{0, wpool_pkg::REG_MODE, 0, 16'h8000, 1, 1, 16'h7FFF, 1},
    '{1, wpool_pkg::REG_MODE, wpool_pkg::MODE_MEAN, 0, 0, 0, 0, 0},
    '{0, wpool_pkg::REG_MODE, 0, 16'h8000, 1, 1, 16'h8000, 1},
    // mode three acts as max; scale zero acts as one
    '{1, wpool_pkg::REG_MODE, 3, 0, 0, 0, 0, 0},
    '{1, wpool_pkg::REG_SCALE, 0, 0, 0, 0, 0, 0},
    '{1, wpool_pkg::REG_IN_COLS, 3, 0, 0, 0, 0, 0},
    '{1, wpool_pkg::REG_OUT_COLS, 3, 0, 0, 0, 0, 0},
    '{0, wpool_pkg::REG_MODE, 0, 16'h0F0F, 1, 0, 0, 0},
    '{0, wpool_pkg::REG_MODE, 0, 16'hF0F0, 0, 0, 0, 0},
    '{0, wpool_pkg::REG_MODE, 0, 16'h5A5A, 0, 0, 0, 0},
    // out_rows zero: nothing is produced
    '{1, wpool_pkg::REG_OUT_ROWS, 0, 0, 0, 0, 0, 0},
    '{0, wpool_pkg::REG_MODE, 0, 16'h7FFF, 1, 0, 0, 0}
  };

  initial begin
    int unsigned sc_eff, ic_eff, orow_eff, len, m, sc, orows, ocols, icols;
    bit tidy;
    pooled_t want;
    foreach (col_acc[i]) col_acc[i] = '0;
    pos_col = 0; pos_row = 0; win_line = 0; win_row_idx = 0;
    r_mode = wpool_pkg::MODE_MAX; r_scale = 2; r_out_rows = 1; r_out_cols = 1;
    r_in_cols = 2;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        want.pooled = dir_rows[i].want_pooled;
        want.last = dir_rows[i].want_last;
        send_sample(dir_rows[i].sample, dir_rows[i].fs, dir_rows[i].typed, want);
      end
    end

    // Widest output row, then the largest window.
    write_all(wpool_pkg::MODE_MEAN, 1, 1, wpool_pkg::MAX_OUT_COLS, wpool_pkg::MAX_OUT_COLS);
    for (int i = 0; i < wpool_pkg::MAX_OUT_COLS; i++) send_sample(pick_sample(), 0, 0, '0);
    write_all(wpool_pkg::MODE_L2, wpool_pkg::MAX_SCALE, 2, 1, wpool_pkg::MAX_SCALE);
    for (int i = 0; i < 128; i++) send_sample(pick_sample(), 0, 0, '0);

    while (sent_samples < ITEM_TARGET) begin
      m = $urandom_range(0, 3);
      sc = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) * $urandom_range(0, 1)
                                       : $urandom_range(1, wpool_pkg::MAX_SCALE);
      sc_eff = (sc == 0) ? 1 : (sc > wpool_pkg::MAX_SCALE ? wpool_pkg::MAX_SCALE : sc);
      case ($urandom_range(0, 11))
        0: icols = 0;
        1: icols = $urandom_range(wpool_pkg::MAX_IN_COLS, 8191);
        default: icols = sc_eff * $urandom_range(1, 5) + $urandom_range(0, sc_eff - 1);
      endcase
      case ($urandom_range(0, 11))
        0: ocols = 0;
        1: ocols = $urandom_range(wpool_pkg::MAX_OUT_COLS, 511);
        default: ocols = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 11))
        0: orows = 0;
        1: orows = $urandom_range(wpool_pkg::MAX_OUT_ROWS, 8191);
        default: orows = $urandom_range(1, 3);
      endcase
      write_all(m, sc, orows, ocols, icols);
      ic_eff = (icols == 0) ? 1 :
               (icols > wpool_pkg::MAX_IN_COLS ? wpool_pkg::MAX_IN_COLS : icols);
      orow_eff = (orows > 4) ? 4 : orows;
      repeat ($urandom_range(1, 3)) begin
        tidy = ($urandom_range(0, 4) != 0);
        len = tidy ? ic_eff * sc_eff * (orow_eff == 0 ? 1 : orow_eff)
                   : $urandom_range(1, 40);
        if (len > 300) len = 300;
        for (int i = 0; i < len && sent_samples < ITEM_TARGET; i++)
          send_sample(pick_sample(), (i == 0) ? tidy : ($urandom_range(0, 7) == 0) & !tidy,
                      0, '0);
      end
    end

    drain();
    $display("Sent %0d samples (%0d inside pooled regions) over %0d register settings;",
             sent_samples, used_samples, cfg_sets);
    $display("checked %0d pooled results across mean, max and L2 modes.", pooled_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
